FILE: hw/rtl/lfd_pkg.sv
// Shared constants, codes and types of the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lfd_pkg;

  // Byte buffer size for both the accumulator and the stored frame.
  localparam int BUF_BYTES  = 512;
  localparam int ADDR_W     = $clog2(BUF_BYTES);
  localparam int CNT_W      = $clog2(BUF_BYTES + 1);
  localparam int TOT_W      = 17;

  // Frame layout: length high byte at position 6, low byte at 7, total adds 11.
  localparam int LEN_HI_POS = 6;
  localparam int LEN_LO_POS = 7;
  localparam int LEN_OFFSET = 11;

  // Result queue in front of the output port.
  localparam int OUT_DEPTH  = 3;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  localparam int CFG_AW     = 1;
  localparam logic [CFG_AW-1:0] CFG_HEAD = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_TAIL = 1'b1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DROP     = 3'd0,
    ST_STORED   = 3'd1,
    ST_GOOD     = 3'd2,
    ST_BAD_TAIL = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_DONE     = 3'd5
  } status_e;

  typedef struct packed {
    status_e          status;
    logic             ready;
    logic [CNT_W-1:0] len;
    logic [7:0]       rdata;
  } res_t;

endpackage

FILE: hw/rtl/lfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module lfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/lfd_out_fifo.sv
// Small result queue that decouples the output port from the processing stage.
`timescale 1ns / 1ps
module lfd_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lfd_pkg::res_t                 push_data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output lfd_pkg::res_t                 data_o,
  output logic [lfd_pkg::OUT_CNT_W-1:0] count_o
);
  import lfd_pkg::*;

  res_t                 entry_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + OUT_CNT_W'(push_i) - OUT_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The producer reserves space one stage ahead, so a push never meets a full queue.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |-> (cnt_q != OUT_CNT_W'(OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("result queue count did not advance on push");

endmodule

FILE: hw/rtl/length_prefixed_frame_deframer.sv
// Top level: byte deframer with head/tail checks, length field and stored frame.
// A result passes the processing-stage register and the result queue before it is offered.
// Throughput: one item per cycle unless the result queue has no room or the input is stalled. A good
// frame keeps a copy from the accumulator bank into the frame store busy; a frame completing during
// the copy waits at the input, and a read of the frame being copied pauses the copy.
// Reset clears counters, flags and config; the byte memories are not cleared (no sweep).
`timescale 1ns / 1ps
module length_prefixed_frame_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write port
  input  logic                       cfg_we_i,
  input  logic [lfd_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [7:0]                 cfg_wdata_i,
  // Input items
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [23:0]                s_axis_tdata_i,  // data_byte[7:0], read_index[16:8]
  input  logic [1:0]                 s_axis_tuser_i,  // cmd[1:0]
  // Result items
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [23:0]                m_axis_tdata_o,  // frame_ready[0], frame_length[10:1],
                                                      // read_data[18:11]
  output logic [2:0]                 m_axis_tuser_o   // status[2:0]
);
  import lfd_pkg::*;

  // Configuration
  logic [7:0] head_q, tail_q;

  // Accumulator and frame state
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [TOT_W-1:0]  exp_q, exp_d;
  logic [7:0]        byte6_q;
  logic              ready_q, ready_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic              sel_q, sel_d;      // bank that the accumulator writes

  // Copy engine from the pending bank into the frame store
  logic              cp_active_q;
  logic [ADDR_W-1:0] cp_ptr_q;
  logic              cp_wr_q;
  logic [ADDR_W-1:0] cp_wa_q;
  logic              cp_busy, cp_step, cp_last;

  // Processing stage between the RAM read and the result queue
  logic              p_valid_q;
  status_e           p_status_q;
  logic              p_ready_q;
  logic [CNT_W-1:0]  p_len_q;
  logic              p_rd_q, p_bank_src_q, p_bank_id_q;

  // Item fields and per-item logic
  logic              in_fire;
  cmd_e              cmd;
  logic [7:0]        data;
  logic [ADDR_W-1:0] ridx;
  logic              ovf, keep, done, good, push_wr, good_fire, bank_rd, stall, space;
  logic [CNT_W-1:0]  f0, f1;
  logic [TOT_W-1:0]  e0, e1;
  status_e           status;

  // Memories
  logic [7:0]        bank0_rdata, bank1_rdata, pend_rdata, store_rdata;
  logic [ADDR_W-1:0] bank_raddr;

  // Result queue
  res_t                 res_in, res_out;
  logic [OUT_CNT_W-1:0] q_cnt;
  logic                 q_valid;

  assign cmd  = cmd_e'(s_axis_tuser_i);
  assign data = s_axis_tdata_i[7:0];
  assign ridx = s_axis_tdata_i[8 +: ADDR_W];

  assign cp_busy = cp_active_q || cp_wr_q;

  // Hold an item back if it could close a frame while the last one is still copied, or if the result queue has no room.
  assign stall = cp_busy && (exp_q != '0) && ((TOT_W'(fill_q) + 1'b1) == exp_q);
  assign space = ({1'b0, q_cnt} + (OUT_CNT_W + 1)'(p_valid_q)) < (OUT_CNT_W + 1)'(OUT_DEPTH);
  assign s_axis_tready_o = space && !stall;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    ovf  = (fill_q == CNT_W'(BUF_BYTES));
    f0   = ovf ? '0 : fill_q;
    e0   = ovf ? '0 : exp_q;
    f1   = f0 + 1'b1;
    keep = !((f0 == '0) && (data != head_q));
    e1   = (f0 == CNT_W'(LEN_LO_POS)) ?
           (TOT_W'({byte6_q, data}) + TOT_W'(LEN_OFFSET)) : e0;
    done = keep && (f1 >= CNT_W'(LEN_LO_POS + 1)) && (e1 <= TOT_W'(BUF_BYTES)) &&
           (TOT_W'(f1) == e1);
    good = done && (data == tail_q);

    status    = ST_DONE;
    fill_d    = fill_q;
    exp_d     = exp_q;
    ready_d   = ready_q;
    len_d     = len_q;
    sel_d     = sel_q;
    push_wr   = 1'b0;
    good_fire = 1'b0;
    bank_rd   = 1'b0;

    unique case (cmd)
      CMD_PUSH: begin
        if (!keep) begin
          status = ovf ? ST_OVERFLOW : ST_DROP;
          fill_d = f0;
          exp_d  = e0;
        end else begin
          push_wr = in_fire;
          if (done) begin
            status = good ? ST_GOOD : ST_BAD_TAIL;
            fill_d = '0;
            exp_d  = '0;
            if (good) begin
              good_fire = in_fire;
              ready_d   = 1'b1;
              len_d     = e1[CNT_W-1:0];
              sel_d     = ~sel_q;
            end
          end else begin
            status = ovf ? ST_OVERFLOW : ST_STORED;
            fill_d = f1;
            exp_d  = e1;
          end
        end
      end
      CMD_READ: begin
        // Bytes of the frame still being copied come from its bank.
        bank_rd = in_fire && cp_busy && ({1'b0, ridx} < len_q);
      end
      CMD_FLUSH: begin
        fill_d  = '0;
        exp_d   = '0;
        ready_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign cp_step = cp_active_q && !bank_rd;
  assign cp_last = (CNT_W'(cp_ptr_q) + 1'b1) == len_q;
  assign bank_raddr = bank_rd ? ridx : cp_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_HEAD: head_q <= cfg_wdata_i;
        CFG_TAIL: tail_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      exp_q       <= '0;
      ready_q     <= 1'b0;
      len_q       <= '0;
      sel_q       <= 1'b0;
      cp_active_q <= 1'b0;
      cp_ptr_q    <= '0;
      cp_wr_q     <= 1'b0;
      p_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        fill_q  <= fill_d;
        exp_q   <= exp_d;
        ready_q <= ready_d;
        len_q   <= len_d;
        sel_q   <= sel_d;
      end
      if (good_fire) begin
        cp_active_q <= 1'b1;
        cp_ptr_q    <= '0;
      end else if (cp_step) begin
        cp_ptr_q <= cp_ptr_q + 1'b1;
        if (cp_last) begin
          cp_active_q <= 1'b0;
        end
      end
      cp_wr_q   <= cp_step;
      p_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_wr && (f0 == CNT_W'(LEN_HI_POS))) begin
      byte6_q <= data;
    end
    cp_wa_q      <= cp_ptr_q;
    p_status_q   <= status;
    p_ready_q    <= ready_d;
    p_len_q      <= len_d;
    p_rd_q       <= (cmd == CMD_READ);
    p_bank_src_q <= bank_rd;
    p_bank_id_q  <= ~sel_q;
  end

  // Two accumulator banks swap roles on every good frame.
  lfd_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (push_wr && !sel_q),
    .waddr_i (f0[ADDR_W-1:0]),
    .wdata_i (data),
    .raddr_i (bank_raddr),
    .rdata_o (bank0_rdata)
  );

  lfd_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (push_wr && sel_q),
    .waddr_i (f0[ADDR_W-1:0]),
    .wdata_i (data),
    .raddr_i (bank_raddr),
    .rdata_o (bank1_rdata)
  );

  assign pend_rdata = sel_q ? bank0_rdata : bank1_rdata;

  lfd_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (cp_wr_q),
    .waddr_i (cp_wa_q),
    .wdata_i (pend_rdata),
    .raddr_i (ridx),
    .rdata_o (store_rdata)
  );

  always_comb begin
    res_in.status = p_status_q;
    res_in.ready  = p_ready_q;
    res_in.len    = p_len_q;
    if (!p_rd_q) begin
      res_in.rdata = '0;
    end else if (p_bank_src_q) begin
      res_in.rdata = p_bank_id_q ? bank1_rdata : bank0_rdata;
    end else begin
      res_in.rdata = store_rdata;
    end
  end

  lfd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (p_valid_q),
    .push_data_i (res_in),
    .pop_i       (m_axis_tready_i),
    .valid_o     (q_valid),
    .data_o      (res_out),
    .count_o     (q_cnt)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tuser_o  = res_out.status;
  assign m_axis_tdata_o  = {5'b0, res_out.rdata, res_out.len, res_out.ready};

  // A new frame must never swap banks while the previous one is still being copied.
  a_no_swap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    good_fire |-> !cp_busy)
    else $error("good frame completed during frame copy");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(BUF_BYTES))
    else $error("fill count beyond buffer size");

  a_cp_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_active_q |-> (CNT_W'(cp_ptr_q) < len_q))
    else $error("copy pointer beyond stored frame length");

  a_ready_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (len_q >= CNT_W'(LEN_OFFSET)))
    else $error("frame ready with a length below the minimum frame");

endmodule

FILE: dv/length_prefixed_frame_deframer_tb.sv
// Self-checking testbench of the length-prefixed frame deframer, driven through its streams.
`timescale 1ns / 1ps
module length_prefixed_frame_deframer_tb;
  import lfd_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = BUF_BYTES + 16;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 80;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        data;
    logic [ADDR_W-1:0] idx;
    logic              known;
    res_t              want;
  } item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = CFG_HEAD;
  logic [7:0]        cfg_wdata_i = 8'd0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [23:0]       s_axis_tdata_i = 24'd0;
  logic [1:0]        s_axis_tuser_i = 2'd0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [23:0]       m_axis_tdata_o;
  logic [2:0]        m_axis_tuser_o;

  // Predicted state of the deframer.
  logic [7:0]  acc_bytes [BUF_BYTES];
  logic [7:0]  kept_frame [BUF_BYTES];
  int unsigned acc_fill = 0;
  int unsigned frame_total = 0;
  int unsigned kept_len = 0;
  int unsigned kept_extent = 0;
  logic        kept_ready = 1'b0;
  logic [7:0]  head_val = 8'd0;
  logic [7:0]  tail_val = 8'd0;

  res_t        expected_results [$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  logic        idle_on = 1'b1;
  logic        hold_request = 1'b0;

  length_prefixed_frame_deframer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic res_t deframe_step(input logic [1:0] cmd, input logic [7:0] data,
                                        input logic [ADDR_W-1:0] idx);
    res_t r;
    r.status = ST_DONE;
    r.rdata  = 8'd0;
    if (cmd == CMD_PUSH) begin
      r.status = ST_STORED;
      if (acc_fill >= BUF_BYTES) begin
        acc_fill    = 0;
        frame_total = 0;
        r.status    = ST_OVERFLOW;
      end
      if (acc_fill == 0 && data != head_val) begin
        if (r.status != ST_OVERFLOW) r.status = ST_DROP;
      end else begin
        acc_bytes[acc_fill] = data;
        acc_fill++;
        if (acc_fill == LEN_LO_POS + 1)
          frame_total = {acc_bytes[LEN_HI_POS], acc_bytes[LEN_LO_POS]} + LEN_OFFSET;
        if (acc_fill > LEN_LO_POS && frame_total <= BUF_BYTES && acc_fill == frame_total) begin
          if (data == tail_val) begin
            for (int i = 0; i < frame_total; i++) kept_frame[i] = acc_bytes[i];
            kept_len   = frame_total;
            kept_ready = 1'b1;
            if (frame_total > kept_extent) kept_extent = frame_total;
            r.status = ST_GOOD;
          end else begin
            r.status = ST_BAD_TAIL;
          end
          acc_fill    = 0;
          frame_total = 0;
        end
      end
    end else if (cmd == CMD_READ) begin
      r.rdata = kept_frame[idx];
    end else if (cmd == CMD_FLUSH) begin
      acc_fill    = 0;
      frame_total = 0;
      kept_ready  = 1'b0;
    end
    r.ready = kept_ready;
    r.len   = kept_len[CNT_W-1:0];
    return r;
  endfunction

  function automatic item_t drow(input logic [1:0] cmd, input logic [7:0] data,
                                 input logic [ADDR_W-1:0] idx, input int known,
                                 input status_e st, input int rdy, input int len,
                                 input logic [7:0] rd);
    item_t it;
    it.cmd          = cmd;
    it.data         = data;
    it.idx          = idx;
    it.known        = known[0];
    it.want.status  = st;
    it.want.ready   = rdy[0];
    it.want.len     = len[CNT_W-1:0];
    it.want.rdata   = rd;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at result %0d", what, got, want, results_seen);
    mismatch_count++;
  endtask

  // Drives one item, waits for it to be taken and records what it should produce.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [ADDR_W-1:0] idx, input logic known, input res_t want);
    res_t predicted;
    if (idle_on && $urandom_range(4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, idx, data};
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = deframe_step(cmd, data, idx);
    expected_results.push_back(known ? want : predicted);
    items_sent++;
  endtask

  task automatic send_push(input logic [7:0] b);
    send_item(CMD_PUSH, b, 9'($urandom_range(511)), 1'b0, '0);
  endtask

  task automatic send_flush();
    send_item(CMD_FLUSH, 8'($urandom_range(255)), 9'($urandom_range(511)), 1'b0, '0);
  endtask

  // Reads only positions that some good frame has written.
  task automatic send_read_random();
    int unsigned idx;
    idx = ($urandom_range(7) == 0) ? kept_extent - 1 : $urandom_range(kept_extent - 1);
    send_item(CMD_READ, 8'($urandom_range(255)), idx[ADDR_W-1:0], 1'b0, '0);
  endtask

  // Sends the first cut bytes of a frame of the given total; reads are mixed in now and then.
  task automatic send_frame(input int total, input logic good, input int cut);
    logic [7:0] b;
    int         len_field;
    len_field = total - LEN_OFFSET;
    for (int i = 0; i < total && i < cut; i++) begin
      if (i == 0) b = head_val;
      else if (i == LEN_HI_POS) b = len_field[15:8];
      else if (i == LEN_LO_POS) b = len_field[7:0];
      else if (i == total - 1) begin
        b = tail_val;
        if (!good) while (b == tail_val) b = 8'($urandom_range(255));
      end else b = 8'($urandom_range(255));
      if (kept_extent > 0 && $urandom_range(19) == 0) send_read_random();
      send_push(b);
    end
  endtask

  task automatic send_mix(input int n_items);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) send_frame($urandom_range(11, 24), 1'b1, BUF_BYTES);
      else if (pick < 65) send_frame($urandom_range(11, 24), 1'b0, BUF_BYTES);
      else if (pick < 73) begin
        // Truncated frame, left in the accumulator or flushed away.
        send_frame($urandom_range(11, 24), 1'b1, $urandom_range(1, 9));
        if ($urandom_range(1) == 1) send_flush();
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 4)) send_push(8'($urandom_range(255)));
      end else if (pick < 91 && kept_extent > 0) send_read_random();
      else if (pick < 96) send_flush();
      else send_item(CMD_UNUSED, 8'($urandom_range(255)), 9'($urandom_range(511)), 1'b0, '0);
    end
  endtask

  // Config may only change once every result is out and a frame copy has had time to end.
  task automatic write_config(input logic [7:0] head, input logic [7:0] tail);
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_HEAD;
    cfg_wdata_i <= head;
    @(posedge clk_i);
    cfg_addr_i  <= CFG_TAIL;
    cfg_wdata_i <= tail;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    head_val = head;
    tail_val = tail;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(4) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o[0], m_axis_tdata_o[10:1], m_axis_tdata_o[18:11]};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(got.status), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.ready != want.ready)
          report_mismatch("frame_ready", int'(got.ready), int'(want.ready));
        if (got.len != want.len)
          report_mismatch("frame_length", int'(got.len), int'(want.len));
        if (got.rdata != want.rdata)
          report_mismatch("read_data", int'(got.rdata), int'(want.rdata));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : run
    item_t directed_rows [$];
    // Reset config: head and tail are both zero.
    directed_rows.push_back(drow(CMD_PUSH,   8'hFF, 9'h1FF, 1, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_UNUSED, 8'hAA, 9'h155, 1, ST_DONE,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_FLUSH,  8'h00, 9'h000, 1, ST_DONE,   0, 0, 8'h00));
    // Shortest legal frame: zero length field, eleven bytes in all.
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h0AA, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h01, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h02, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h03, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h04, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h05, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'hFF, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h80, 9'h000, 1, ST_STORED, 0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h000, 1, ST_GOOD,   1, 11, 8'h00));
    directed_rows.push_back(drow(CMD_READ,   8'h5A, 9'h008, 1, ST_DONE,   1, 11, 8'hFF));
    directed_rows.push_back(drow(CMD_FLUSH,  8'hFF, 9'h1FF, 1, ST_DONE,   0, 11, 8'h00));
    // Same shape, but the last byte is not the tail value.
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h100, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h7F, 9'h0FF, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h80, 9'h001, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'hFE, 9'h002, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h01, 9'h004, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h33, 9'h008, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h010, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h00, 9'h020, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'hCC, 9'h040, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h55, 9'h080, 0, ST_DROP,   0, 0, 8'h00));
    directed_rows.push_back(drow(CMD_PUSH,   8'h01, 9'h000, 1, ST_BAD_TAIL, 0, 11, 8'h00));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].data, directed_rows[i].idx,
                directed_rows[i].known, directed_rows[i].want);

    write_config(8'($urandom_range(1, 254)), 8'($urandom_range(255)));
    hold_request = 1'b1;
    send_mix(PHASE_ITEMS);

    // Largest frame the buffer can hold, then reads at both ends of it.
    write_config(8'hFF, 8'h00);
    send_flush();
    send_frame(BUF_BYTES, 1'b1, BUF_BYTES);
    send_item(CMD_READ, 8'h00, 9'h1FF, 1'b0, '0);
    send_item(CMD_READ, 8'hFF, 9'h000, 1'b0, '0);
    send_mix(PHASE_ITEMS);

    // Length field at its maximum: the frame cannot fit, so the buffer overflows.
    write_config(8'h00, 8'hFF);
    send_flush();
    send_frame(16'hFFFF + LEN_OFFSET, 1'b1, BUF_BYTES);
    send_push(($urandom_range(1) == 1) ? head_val : ~head_val);
    send_mix(PHASE_ITEMS);

    write_config(8'($urandom_range(255)), 8'($urandom_range(255)));
    idle_on = 1'b0;
    send_mix(PHASE_ITEMS);

    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
